>>> hw/rtl/ppfc_pkg.sv
// Package for the packed pixel format converter.
// Holds register indexes, format codes and the constant dividers; depends on nothing.
package ppfc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned NUM_W  = 14;
    localparam int unsigned FMT_W  = 3;
    localparam int unsigned CNT_W  = 3;

    localparam logic CFG_DIRECTION    = 1'b0;
    localparam logic CFG_PIXEL_FORMAT = 1'b1;

    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    localparam logic [FMT_W-1:0] FMT_ARGB8 = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RGBA8 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_A8    = 3'd2;
    localparam logic [FMT_W-1:0] FMT_R8    = 3'd3;
    localparam logic [FMT_W-1:0] FMT_565   = 3'd4;
    localparam logic [FMT_W-1:0] FMT_5551  = 3'd5;

    localparam logic [CNT_W-1:0] CNT_NONE  = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
    localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;

    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;

    localparam logic [31:0] RECIP_31 = 32'd8457;
    localparam logic [31:0] RECIP_63 = 32'd16645;

    typedef enum logic [1:0]
    {
        DIV_BY_255,
        DIV_BY_31,
        DIV_BY_63
    } div_sel_t;

    // Exact for all 14-bit numerators, below 16384.
    function automatic logic [BYTE_W-1:0] div255(input logic [NUM_W-1:0] x);
        logic [15:0] s;
        s = {2'b00, x} + 16'd1 + {10'd0, x[13:8]};
        return s[15:8];
    endfunction

    // Exact for numerators up to 31 * 255.
    function automatic logic [BYTE_W-1:0] div31(input logic [NUM_W-1:0] x);
        logic [31:0] pr;
        pr = {18'd0, x} * RECIP_31;
        return pr[25:18];
    endfunction

    // Exact for numerators up to 63 * 255.
    function automatic logic [BYTE_W-1:0] div63(input logic [NUM_W-1:0] x);
        logic [31:0] pr;
        pr = {18'd0, x} * RECIP_63;
        return pr[27:20];
    endfunction

endpackage

>>> hw/rtl/packed_pixel_format_converter.sv
// Top level of the packed pixel format converter: decodes packed pixels to BGRA or encodes
// RGBA to a packed layout. Depends on ppfc_pkg.
// Throughput is one item per cycle while out_stall is low; each item passes through the
// three-stage pipeline that sets the rate: operand scaling, reciprocal multiply, packing.
// Reset clears the stage valid bits and sets direction and pixel_format to zero.
module packed_pixel_format_converter
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ppfc_pkg::BYTE_W-1:0]  in_byte0,
    input  logic [ppfc_pkg::BYTE_W-1:0]  in_byte1,
    input  logic [ppfc_pkg::BYTE_W-1:0]  in_byte2,
    input  logic [ppfc_pkg::BYTE_W-1:0]  in_byte3,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ppfc_pkg::BYTE_W-1:0]  out_byte0,
    output logic [ppfc_pkg::BYTE_W-1:0]  out_byte1,
    output logic [ppfc_pkg::BYTE_W-1:0]  out_byte2,
    output logic [ppfc_pkg::BYTE_W-1:0]  out_byte3,
    output logic [ppfc_pkg::CNT_W-1:0]   byte_count,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [ppfc_pkg::FMT_W-1:0]   cfg_data
);
    import ppfc_pkg::*;

    logic              direction_reg;
    logic [FMT_W-1:0]  pixel_format_reg;

    logic              s1_valid_reg;
    logic              s1_dir_reg;
    logic [FMT_W-1:0]  s1_fmt_reg;
    logic [BYTE_W-1:0] s1_byte_reg [4];
    logic [NUM_W-1:0]  s1_num_reg [3];
    div_sel_t          s1_div_reg [3];

    logic              s2_valid_reg;
    logic              s2_dir_reg;
    logic [FMT_W-1:0]  s2_fmt_reg;
    logic [BYTE_W-1:0] s2_byte_reg [4];
    logic [BYTE_W-1:0] s2_quot_reg [3];

    logic              s3_valid_reg;
    logic [BYTE_W-1:0] s3_byte_reg [4];
    logic [CNT_W-1:0]  s3_cnt_reg;

    logic              adv1;
    logic              adv2;
    logic              adv3;

    logic [NUM_W-1:0]  s1_num_next [3];
    div_sel_t          s1_div_next [3];
    logic [BYTE_W-1:0] s2_quot_next [3];
    logic [BYTE_W-1:0] s3_byte_next [4];
    logic [CNT_W-1:0]  s3_cnt_next;

    logic [5:0]        fld [3];
    logic [15:0]       packed_word;

    assign adv3     = !s3_valid_reg || !out_stall;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= DIR_DECODE;
            pixel_format_reg <= FMT_ARGB8;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_DIRECTION)
            begin
                direction_reg <= cfg_data[0];
            end
            else
            begin
                pixel_format_reg <= cfg_data;
            end
        end
    end

    // Stage one: field extraction and scaling by the channel maximum or by 255.
    always_comb
    begin
        if (pixel_format_reg == FMT_565)
        begin
            fld[0] = {1'b0, in_byte0[4:0]};
            fld[1] = {in_byte1[2:0], in_byte0[7:5]};
            fld[2] = {1'b0, in_byte1[7:3]};
        end
        else
        begin
            fld[0] = {1'b0, in_byte0[4:0]};
            fld[1] = {1'b0, in_byte1[1:0], in_byte0[7:5]};
            fld[2] = {1'b0, in_byte1[6:2]};
        end

        if (direction_reg == DIR_DECODE)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_num_next[k] = {fld[k], 8'd0} - {8'd0, fld[k]};
                s1_div_next[k] = DIV_BY_31;
            end
            if (pixel_format_reg == FMT_565)
            begin
                s1_div_next[1] = DIV_BY_63;
            end
        end
        else
        begin
            s1_num_next[0] = {1'b0, in_byte0, 5'd0} - {6'd0, in_byte0};
            s1_num_next[2] = {1'b0, in_byte2, 5'd0} - {6'd0, in_byte2};
            if (pixel_format_reg == FMT_565)
            begin
                s1_num_next[1] = {in_byte1, 6'd0} - {6'd0, in_byte1};
            end
            else
            begin
                s1_num_next[1] = {1'b0, in_byte1, 5'd0} - {6'd0, in_byte1};
            end
            for (int k = 0; k < 3; k++)
            begin
                s1_div_next[k] = DIV_BY_255;
            end
        end
    end

    // Stage two: division by a constant through a reciprocal multiply.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            unique case (s1_div_reg[k])
                DIV_BY_31:  s2_quot_next[k] = div31(s1_num_reg[k]);
                DIV_BY_63:  s2_quot_next[k] = div63(s1_num_reg[k]);
                default:    s2_quot_next[k] = div255(s1_num_reg[k]);
            endcase
        end
    end

    // Stage three: byte placement and packing.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            s3_byte_next[k] = '0;
        end
        s3_cnt_next = CNT_NONE;
        packed_word = '0;

        if (s2_dir_reg == DIR_DECODE)
        begin
            s3_cnt_next = CNT_FOUR;
            unique case (s2_fmt_reg)
                FMT_ARGB8:
                begin
                    s3_byte_next[0] = s2_byte_reg[0];
                    s3_byte_next[1] = s2_byte_reg[1];
                    s3_byte_next[2] = s2_byte_reg[2];
                    s3_byte_next[3] = s2_byte_reg[3];
                end
                FMT_RGBA8:
                begin
                    s3_byte_next[0] = s2_byte_reg[2];
                    s3_byte_next[1] = s2_byte_reg[1];
                    s3_byte_next[2] = s2_byte_reg[0];
                    s3_byte_next[3] = s2_byte_reg[3];
                end
                FMT_A8, FMT_R8:
                begin
                    s3_byte_next[0] = s2_byte_reg[0];
                    s3_byte_next[1] = s2_byte_reg[0];
                    s3_byte_next[2] = s2_byte_reg[0];
                    s3_byte_next[3] = BYTE_FULL;
                end
                FMT_565:
                begin
                    s3_byte_next[0] = s2_quot_reg[0];
                    s3_byte_next[1] = s2_quot_reg[1];
                    s3_byte_next[2] = s2_quot_reg[2];
                    s3_byte_next[3] = BYTE_FULL;
                end
                FMT_5551:
                begin
                    s3_byte_next[0] = s2_quot_reg[0];
                    s3_byte_next[1] = s2_quot_reg[1];
                    s3_byte_next[2] = s2_quot_reg[2];
                    s3_byte_next[3] = s2_byte_reg[1][7] ? BYTE_FULL : '0;
                end
                default:
                begin
                    s3_cnt_next = CNT_FOUR;
                end
            endcase
        end
        else
        begin
            unique case (s2_fmt_reg)
                FMT_ARGB8:
                begin
                    s3_byte_next[0] = s2_byte_reg[2];
                    s3_byte_next[1] = s2_byte_reg[1];
                    s3_byte_next[2] = s2_byte_reg[0];
                    s3_byte_next[3] = s2_byte_reg[3];
                    s3_cnt_next     = CNT_FOUR;
                end
                FMT_RGBA8:
                begin
                    s3_byte_next[0] = s2_byte_reg[0];
                    s3_byte_next[1] = s2_byte_reg[1];
                    s3_byte_next[2] = s2_byte_reg[2];
                    s3_byte_next[3] = s2_byte_reg[3];
                    s3_cnt_next     = CNT_FOUR;
                end
                FMT_A8:
                begin
                    s3_byte_next[0] = s2_byte_reg[3];
                    s3_cnt_next     = CNT_ONE;
                end
                FMT_R8:
                begin
                    s3_byte_next[0] = s2_byte_reg[0];
                    s3_cnt_next     = CNT_ONE;
                end
                FMT_565:
                begin
                    packed_word     = {s2_quot_reg[0][4:0], s2_quot_reg[1][5:0],
                                       s2_quot_reg[2][4:0]};
                    s3_byte_next[0] = packed_word[7:0];
                    s3_byte_next[1] = packed_word[15:8];
                    s3_cnt_next     = CNT_TWO;
                end
                FMT_5551:
                begin
                    packed_word     = {s2_byte_reg[3][7], s2_quot_reg[0][4:0],
                                       s2_quot_reg[1][4:0], s2_quot_reg[2][4:0]};
                    s3_byte_next[0] = packed_word[7:0];
                    s3_byte_next[1] = packed_word[15:8];
                    s3_cnt_next     = CNT_TWO;
                end
                default:
                begin
                    s3_cnt_next = CNT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_dir_reg     <= direction_reg;
            s1_fmt_reg     <= pixel_format_reg;
            s1_byte_reg[0] <= in_byte0;
            s1_byte_reg[1] <= in_byte1;
            s1_byte_reg[2] <= in_byte2;
            s1_byte_reg[3] <= in_byte3;
            s1_num_reg     <= s1_num_next;
            s1_div_reg     <= s1_div_next;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_dir_reg  <= s1_dir_reg;
            s2_fmt_reg  <= s1_fmt_reg;
            s2_byte_reg <= s1_byte_reg;
            s2_quot_reg <= s2_quot_next;
        end
        if (adv3 && s2_valid_reg)
        begin
            s3_byte_reg <= s3_byte_next;
            s3_cnt_reg  <= s3_cnt_next;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_byte0  = s3_byte_reg[0];
    assign out_byte1  = s3_byte_reg[1];
    assign out_byte2  = s3_byte_reg[2];
    assign out_byte3  = s3_byte_reg[3];
    assign byte_count = s3_cnt_reg;

endmodule

>>> hw/rtl/ppfc_checker.sv
// Port-level checker for the packed pixel format converter, with its bind statement.
// Depends on ppfc_pkg and on the top level's ports.
module ppfc_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_stall,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [ppfc_pkg::BYTE_W-1:0]  out_byte0,
    input  logic [ppfc_pkg::BYTE_W-1:0]  out_byte1,
    input  logic [ppfc_pkg::BYTE_W-1:0]  out_byte2,
    input  logic [ppfc_pkg::BYTE_W-1:0]  out_byte3,
    input  logic [ppfc_pkg::CNT_W-1:0]   byte_count
);
    import ppfc_pkg::*;

    // The input is only held back when the whole pipeline is full behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the pipeline can still move");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count == CNT_NONE || byte_count == CNT_ONE ||
                       byte_count == CNT_TWO || byte_count == CNT_FOUR))
        else $error("byte count outside the legal set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_count == CNT_ONE) |->
        (out_byte1 == '0 && out_byte2 == '0 && out_byte3 == '0))
        else $error("unused result bytes are not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled item withdrawn");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        ($stable(out_byte0) && $stable(out_byte1) && $stable(out_byte2) &&
         $stable(out_byte3) && $stable(byte_count)))
        else $error("stalled item changed");

endmodule

bind packed_pixel_format_converter ppfc_checker u_ppfc_checker (.*);
